[rtl/fwf_pkg.sv]
// Package for the flush-when-full page residency tracker.
// Holds field widths, configuration register codes and reset values.
// No dependencies; every other file of the block imports it.
package fwf_pkg;

    localparam int ADDR_W        = 32;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_W        = ADDR_W - PAGE_SHIFT;
    localparam int FIELD6_W      = 6;
    localparam int TOTAL_W       = 32;

    localparam int CFG_FRAMES_W  = 7;
    localparam int CFG_LIMIT_W   = 16;
    localparam int CFG_QUANTUM_W = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam int BLOCK_W       = 17;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

    localparam int DEF_SLOTS_PER_PROCESS = 32;
    localparam int DEF_COUNTER_BITS      = 32;

    localparam logic [CFG_FRAMES_W-1:0]  RST_TOTAL_FRAMES = 7'd64;
    localparam logic [CFG_LIMIT_W-1:0]   RST_FAULT_LIMIT  = 16'd65535;
    localparam logic [CFG_QUANTUM_W-1:0] RST_QUANTUM      = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_FRAMES = 2'd0,
        CFG_FAULT_LIMIT  = 2'd1,
        CFG_QUANTUM      = 2'd2
    } t_cfg_idx;

endpackage

[rtl/fwf_req_if.sv]
// Request channel of the page residency tracker: one memory access per transfer.
// Depends on fwf_pkg for the field widths.
interface fwf_req_if;
    import fwf_pkg::*;

    logic              valid;
    logic              ready;
    logic              process_id;
    logic [ADDR_W-1:0] address;
    logic              write_op;

    modport source (output valid, output process_id, output address, output write_op,
                    input ready);
    modport sink   (input valid, input process_id, input address, input write_op,
                    output ready);
endinterface

[rtl/fwf_rsp_if.sv]
// Response channel of the page residency tracker: one result per access.
// Depends on fwf_pkg for the field widths.
interface fwf_rsp_if;
    import fwf_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic                page_fault;
    logic                flushed;
    logic [FIELD6_W-1:0] writebacks;
    logic [FIELD6_W-1:0] frames_used;
    logic [TOTAL_W-1:0]  requests_total;
    logic [TOTAL_W-1:0]  faults_total;
    logic [TOTAL_W-1:0]  disk_writes_total;

    modport source (output valid, output hit, output page_fault, output flushed,
                    output writebacks, output frames_used, output requests_total,
                    output faults_total, output disk_writes_total, input ready);
    modport sink   (input valid, input hit, input page_fault, input flushed,
                    input writebacks, input frames_used, input requests_total,
                    input faults_total, input disk_writes_total, output ready);
endinterface

[rtl/fwf_page_residency_tracker_unit.sv]
// Top level of the flush-when-full page residency tracker.
// Depends on fwf_pkg, fwf_req_if and fwf_rsp_if.
//
// Usage:
//   i_req  - access requests (process, byte address, read/write). A transfer
//            happens on a rising edge with valid and ready both high.
//   o_rsp  - one result per request, in request order: hit/fault/flush flags,
//            write-backs of the flush, resident pages of the process and its
//            saturating request, fault and write-back totals.
//   i_cfg_* - register writes (frame total, fault limit, quantum), taken on
//            any edge with i_cfg_we high; write only while the block is idle.
// Path: a request lands in the input register, is resolved by one pass of
//   compare / popcount logic, and its result is loaded into the result register
//   that drives o_rsp. Throughput is one request per cycle while o_rsp is not
//   held; the per-process state is updated in the same edge that loads the
//   result register, so back-to-back requests see each other's effect.
// Stall: while o_rsp is held, the result register holds, the input register
//   holds one more request, and i_req.ready drops once both are full.
// Reset (synchronous, i_rst_n low): clear occupancy, fault block, quantum and
//   total counters and restore register defaults. Page slots and dirty marks
//   are not cleared; only slots below the occupancy count are ever looked at.
module fwf_page_residency_tracker_unit #(
    parameter int SLOTS_PER_PROCESS = fwf_pkg::DEF_SLOTS_PER_PROCESS,
    parameter int COUNTER_BITS      = fwf_pkg::DEF_COUNTER_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fwf_req_if.sink                         i_req,
    fwf_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fwf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fwf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import fwf_pkg::*;

    localparam int SW  = (SLOTS_PER_PROCESS > 1) ? $clog2(SLOTS_PER_PROCESS) : 1;
    localparam int UW  = $clog2(SLOTS_PER_PROCESS + 1);
    localparam int TWS = $clog2(2 * SLOTS_PER_PROCESS + 1);
    localparam int TW  = (TWS > CFG_FRAMES_W) ? TWS : CFG_FRAMES_W;
    localparam int CW  = COUNTER_BITS;

    localparam logic [TW-1:0] T_MIN     = TW'(2);
    localparam logic [TW-1:0] T_MAX     = TW'(2 * SLOTS_PER_PROCESS);
    localparam logic [TW-1:0] T_SLOTS   = TW'(SLOTS_PER_PROCESS);
    localparam logic [CW-1:0] CNT_MAX   = '1;

    // configuration registers
    logic [CFG_FRAMES_W-1:0]  r_total_frames;
    logic [CFG_LIMIT_W-1:0]   r_fault_limit;
    logic [CFG_QUANTUM_W-1:0] r_quantum;

    // input register
    logic              r_in_valid;
    logic              r_in_pid;
    logic [PAGE_W-1:0] r_in_page;
    logic              r_in_wr;

    // page slots and dirty marks, one row per process
    logic [PAGE_W-1:0] r_pages [2][SLOTS_PER_PROCESS];
    logic              r_dirty [2][SLOTS_PER_PROCESS];

    // per-process state
    logic [UW-1:0]            r_used [2];
    logic [BLOCK_W-1:0]       r_fblk [2];
    logic [CFG_QUANTUM_W-1:0] r_qcnt [2];
    logic [CW-1:0]            r_req  [2];
    logic [CW-1:0]            r_flt  [2];
    logic [CW-1:0]            r_wbk  [2];

    // result register
    logic                r_out_valid;
    logic                r_out_hit;
    logic                r_out_fault;
    logic                r_out_flushed;
    logic [FIELD6_W-1:0] r_out_wbs;
    logic [FIELD6_W-1:0] r_out_used;
    logic [TOTAL_W-1:0]  r_out_req;
    logic [TOTAL_W-1:0]  r_out_flt;
    logic [TOTAL_W-1:0]  r_out_wbk;

    // handshake: the result register frees when empty or taken
    logic w_adv;
    logic w_step;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_step      = r_in_valid && w_adv;
    assign i_req.ready = !r_in_valid || w_adv;

    // lookup and update logic for the item in the input register
    logic [SLOTS_PER_PROCESS-1:0] w_match;
    logic                         w_hit;
    logic [UW-1:0]                w_pop;
    logic                         w_flush;
    logic                         w_ins;
    logic [SW-1:0]                w_slot;
    logic [UW-1:0]                w_used_new;
    logic [UW-1:0]                w_wbs;
    logic [BLOCK_W-1:0]           w_fblk_new;
    logic [CFG_QUANTUM_W-1:0]     w_qcnt_new;
    logic [CW-1:0]                w_req_new;
    logic [CW-1:0]                w_flt_new;
    logic [CW-1:0]                w_wbk_new;
    logic [CW+TOTAL_W-1:0]        w_req_ext;
    logic [CW+TOTAL_W-1:0]        w_flt_ext;
    logic [CW+TOTAL_W-1:0]        w_wbk_ext;
    logic [UW+FIELD6_W-1:0]       w_wbs_ext;
    logic [UW+FIELD6_W-1:0]       w_used_ext;

    always_comb begin
        logic [TW-1:0]            v_t;
        logic [TW-1:0]            v_half;
        logic [TW-1:0]            v_cap;
        logic [TW-1:0]            v_used_t;
        logic [UW-1:0]            v_used;
        logic [UW-1:0]            v_used_af;
        logic [BLOCK_W-1:0]       v_fb;
        logic [BLOCK_W-1:0]       v_fb_inc;
        logic [CFG_QUANTUM_W-1:0] v_qnext;
        logic [CFG_QUANTUM_W-1:0] v_qlim;
        logic [CW:0]              v_wsum;

        // clamp the frame total and split it between the processes
        v_t = TW'(r_total_frames);
        if (v_t < T_MIN) begin
            v_t = T_MIN;
        end
        if (v_t > T_MAX) begin
            v_t = T_MAX;
        end
        v_half   = v_t >> 1;
        v_cap    = r_in_pid ? (v_t - v_half) : v_half;
        v_used   = r_used[r_in_pid];
        v_used_t = TW'(v_used);

        // parallel compare over the live slots, popcount of live dirty marks
        w_pop = '0;
        for (int i = 0; i < SLOTS_PER_PROCESS; i++) begin
            w_match[i] = (TW'(i) < v_used_t) && (r_pages[r_in_pid][i] == r_in_page);
            if ((TW'(i) < v_used_t) && r_dirty[r_in_pid][i]) begin
                w_pop = w_pop + UW'(1);
            end
        end
        w_hit = |w_match;

        // fault block and flush decision
        v_fb     = r_fblk[r_in_pid];
        v_fb_inc = (v_fb != BLOCK_MAX) ? v_fb + BLOCK_W'(1) : v_fb;
        w_flush  = !w_hit && ((v_fb_inc > BLOCK_W'(r_fault_limit)) || (v_used_t >= v_cap));

        v_used_af  = w_flush ? '0 : v_used;
        w_ins      = !w_hit && (TW'(v_used_af) < T_SLOTS);
        w_slot     = v_used_af[SW-1:0];
        w_used_new = w_ins ? v_used_af + UW'(1) : v_used_af;
        w_wbs      = w_flush ? w_pop : '0;

        if (w_flush) begin
            w_fblk_new = BLOCK_W'(1);
        end else if (!w_hit) begin
            w_fblk_new = v_fb_inc;
        end else begin
            w_fblk_new = v_fb;
        end

        // quantum: clear the fault block count at the end of each quantum
        v_qnext = r_qcnt[r_in_pid] + CFG_QUANTUM_W'(1);
        v_qlim  = (r_quantum == '0) ? CFG_QUANTUM_W'(1) : r_quantum;
        if ((v_qnext >= v_qlim) || (v_qnext == '0)) begin
            w_qcnt_new = '0;
            w_fblk_new = '0;
        end else begin
            w_qcnt_new = v_qnext;
        end

        // saturating totals
        w_req_new = (r_req[r_in_pid] != CNT_MAX) ? r_req[r_in_pid] + CW'(1) : CNT_MAX;
        if (!w_hit && (r_flt[r_in_pid] != CNT_MAX)) begin
            w_flt_new = r_flt[r_in_pid] + CW'(1);
        end else begin
            w_flt_new = r_flt[r_in_pid];
        end
        v_wsum    = {1'b0, r_wbk[r_in_pid]} + (CW + 1)'(w_wbs);
        w_wbk_new = v_wsum[CW] ? CNT_MAX : v_wsum[CW-1:0];

        // fit totals and counts to the fixed result field widths
        w_req_ext  = {{TOTAL_W{1'b0}}, w_req_new};
        w_flt_ext  = {{TOTAL_W{1'b0}}, w_flt_new};
        w_wbk_ext  = {{TOTAL_W{1'b0}}, w_wbk_new};
        w_wbs_ext  = {{FIELD6_W{1'b0}}, w_wbs};
        w_used_ext = {{FIELD6_W{1'b0}}, w_used_new};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frames <= RST_TOTAL_FRAMES;
            r_fault_limit  <= RST_FAULT_LIMIT;
            r_quantum      <= RST_QUANTUM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL_FRAMES: r_total_frames <= i_cfg_wdata[CFG_FRAMES_W-1:0];
                CFG_FAULT_LIMIT:  r_fault_limit  <= i_cfg_wdata[CFG_LIMIT_W-1:0];
                CFG_QUANTUM:      r_quantum      <= i_cfg_wdata[CFG_QUANTUM_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_pid  <= i_req.process_id;
            r_in_page <= i_req.address[ADDR_W-1:PAGE_SHIFT];
            r_in_wr   <= i_req.write_op;
        end
    end

    // page slots: insert on a fault, mark dirty on a write hit
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < SLOTS_PER_PROCESS; i++) begin
                if (w_step && (r_in_pid == 1'(p))) begin
                    if (w_ins && (w_slot == SW'(i))) begin
                        r_pages[p][i] <= r_in_page;
                        r_dirty[p][i] <= r_in_wr;
                    end else if (w_match[i] && r_in_wr) begin
                        r_dirty[p][i] <= 1'b1;
                    end
                end
            end
        end
    end

    // per-process counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_used[p] <= '0;
                r_fblk[p] <= '0;
                r_qcnt[p] <= '0;
                r_req[p]  <= '0;
                r_flt[p]  <= '0;
                r_wbk[p]  <= '0;
            end
        end else if (w_step) begin
            r_used[r_in_pid] <= w_used_new;
            r_fblk[r_in_pid] <= w_fblk_new;
            r_qcnt[r_in_pid] <= w_qcnt_new;
            r_req[r_in_pid]  <= w_req_new;
            r_flt[r_in_pid]  <= w_flt_new;
            r_wbk[r_in_pid]  <= w_wbk_new;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_hit     <= w_hit;
            r_out_fault   <= !w_hit;
            r_out_flushed <= w_flush;
            r_out_wbs     <= w_wbs_ext[FIELD6_W-1:0];
            r_out_used    <= w_used_ext[FIELD6_W-1:0];
            r_out_req     <= w_req_ext[TOTAL_W-1:0];
            r_out_flt     <= w_flt_ext[TOTAL_W-1:0];
            r_out_wbk     <= w_wbk_ext[TOTAL_W-1:0];
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.hit               = r_out_hit;
    assign o_rsp.page_fault        = r_out_fault;
    assign o_rsp.flushed           = r_out_flushed;
    assign o_rsp.writebacks        = r_out_wbs;
    assign o_rsp.frames_used       = r_out_used;
    assign o_rsp.requests_total    = r_out_req;
    assign o_rsp.faults_total      = r_out_flt;
    assign o_rsp.disk_writes_total = r_out_wbk;

    // a resolved request always lands in the result register
    a_step_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("resolved request did not reach the result register");

    // every result is exactly one of hit or fault
    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.hit ^ o_rsp.page_fault))
        else $error("result is not exactly one of hit and fault");

    // a flush only happens on a fault, and a non-flush reports no write-backs
    a_flush_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.flushed ? o_rsp.page_fault : (o_rsp.writebacks == '0)))
        else $error("flush flag inconsistent with fault or write-back count");

endmodule
